// ===== hdl/bitmap_signed_distance_query_top_macros.svh =====
// assertion macros for the bitmap signed distance query block
`ifndef BITMAP_SIGNED_DISTANCE_QUERY_TOP_MACROS_SVH
`define BITMAP_SIGNED_DISTANCE_QUERY_TOP_MACROS_SVH
`ifndef SYNTH
`define BSDQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsdq same-cycle check failed");
`define BSDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsdq next-cycle check failed");
`else
`define BSDQ_ASSERT_IMPL(label, ante, cons)
`define BSDQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/bsdq_pkg.sv =====
// shared types and constants of the bitmap signed distance query block
package bsdq_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COORD_IN_W = 6;
  localparam int unsigned FIX_W      = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned DIM_REG_W  = 7;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DCNT_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_W    = 3'd0,
    REG_GRID_H    = 3'd1,
    REG_ORIGIN_X  = 3'd2,
    REG_ORIGIN_Y  = 3'd3,
    REG_CELL_STEP = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_GRID,
    ST_CTR_RD,
    ST_CTR_CK,
    ST_IN_RD,
    ST_IN_CK,
    ST_RING,
    ST_SEG,
    ST_RNG_RD,
    ST_RNG_CK,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_ADV,
    ST_SQRT,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_I,
    MUL_J,
    MUL_AX,
    MUL_AY
  } mul_sel_e;

  typedef enum logic [1:0] {
    RES_OFF_GRID,
    RES_ON_CELL,
    RES_NONE,
    RES_DIST
  } res_sel_e;

  typedef struct packed {
    logic     clr_step;
    logic     pix_wr;
    logic     capture;
    logic     div_step;
    logic     div_to_y;
    logic     div_fin_y;
    logic     ctr_load;
    logic     in_load;
    logic     in_acc;
    logic     step;
    logic     ring_first;
    logic     ring_next;
    logic     side_next;
    logic     seg_load;
    mul_sel_e mul_sel;
    logic     ld_ax;
    logic     ld_ay;
    logic     ld_acc;
    logic     upd_best;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     out_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic off_grid;
    logic x_zero;
    logic pix;
    logic at_end;
    logic seg_ok;
    logic last_side;
    logic ring_over;
    logic best_valid;
    logic sqrt_done;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== hdl/bsdq_if.sv =====
// item channel interfaces of the bitmap signed distance query block
interface bsdq_in_if;
  import bsdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [COORD_IN_W-1:0]    cell_x;
  logic [COORD_IN_W-1:0]    cell_y;
  logic                     pixel_value;
  logic signed [FIX_W-1:0]  point_x;
  logic signed [FIX_W-1:0]  point_y;
  modport source (output valid, kind, cell_x, cell_y, pixel_value, point_x, point_y,
                  input ready);
  modport sink (input valid, kind, cell_x, cell_y, pixel_value, point_x, point_y,
                output ready);
endinterface

interface bsdq_out_if;
  import bsdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FIX_W-1:0]  distance;
  logic                     found;
  logic                     out_of_grid;
  modport source (output valid, distance, found, out_of_grid, input ready);
  modport sink (input valid, distance, found, out_of_grid, output ready);
endinterface

// ===== hdl/bsdq_datapath.sv =====
// datapath: pixel memory, config registers, divider, ring walker, distance and square root
module bsdq_datapath #(
  parameter int MAX_GRID_W = 64,
  parameter int MAX_GRID_H = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bsdq_pkg::dp_cmd_t                     cmd_i,
  output bsdq_pkg::dp_sts_t                     sts_o,
  input  logic                                  cfg_we_i,
  input  logic [bsdq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bsdq_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic [bsdq_pkg::COORD_IN_W-1:0]       cell_x_i,
  input  logic [bsdq_pkg::COORD_IN_W-1:0]       cell_y_i,
  input  logic                                  pixel_value_i,
  input  logic signed [bsdq_pkg::FIX_W-1:0]     point_x_i,
  input  logic signed [bsdq_pkg::FIX_W-1:0]     point_y_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [bsdq_pkg::FIX_W-1:0]     distance_o,
  output logic                                  found_o,
  output logic                                  out_of_grid_o
);
  import bsdq_pkg::*;

  localparam int DEPTH = MAX_GRID_W * MAX_GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_GRID_W > MAX_GRID_H) ? MAX_GRID_W : MAX_GRID_H;
  localparam int DIMW  = $clog2(MAXD + 1);
  localparam int CW    = ((DIMW > DIM_REG_W) ? DIMW : DIM_REG_W) + 2;
  localparam int PW    = 2 * FIX_W;
  localparam int DXW   = FIX_W + 12;
  localparam logic [FIX_W-1:0] AXIS_CLAMP = 32'h8000_0000;
  localparam logic [PW-1:0]    DIST_MAX   = 64'h0000_0000_7FFF_FFFF;

  // config registers
  logic [DIM_REG_W-1:0]     gw_q, gh_q;
  logic signed [FIX_W-1:0]  ox_q, oy_q;
  logic [STEP_W-1:0]        step_q;

  // memory and clear
  logic                     mem_q [DEPTH];
  logic                     rd_q;
  logic [AW-1:0]            clr_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic                     mem_wdata;

  // query state
  logic signed [FIX_W:0]    offx_q, offy_q;
  logic                     negx_q, negy_q;
  logic [FIX_W-1:0]         dvd_y_q;
  logic [FIX_W-1:0]         rem_q, quo_q, qx_q, qy_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic signed [CW-1:0]     x_q, y_q, ci_q, cj_q, end_q, lv_q;
  side_e                    side_q;
  logic                     inside_q;
  logic [PW-1:0]            prod_q, acc_q, best_q;
  logic [FIX_W-1:0]         ax_q, ay_q;
  logic                     bv_q;
  logic [PW-1:0]            sv_q, sres_q, sbit_q;
  logic                     out_valid_q;
  logic signed [FIX_W-1:0]  dist_q;
  logic                     found_q, oog_q;

  // derived
  logic signed [CW-1:0]     w_eff, h_eff, maxlv;
  logic [STEP_W-1:0]        step_eff;
  logic signed [FIX_W:0]    ddx, ddy;
  logic [FIX_W-1:0]         div_trial;
  logic                     div_bit;
  logic [FIX_W-1:0]         div_rem;
  logic                     is_col;
  logic signed [CW-1:0]     fix_c, lo_c, hi_c, cur_c;
  logic signed [CW-1:0]     row_lo, row_hi, col_lo, col_hi, fix_row, fix_col;
  logic                     fix_ok;
  logic [FIX_W-1:0]         mul_a, mul_b;
  logic signed [DXW-1:0]    dx_x, dx_y;
  logic [FIX_W-1:0]         mag_x, mag_y;
  logic [PW-1:0]            sum_sq, sq_t;
  logic [FIX_W-1:0]         dsat;

  function automatic logic [FIX_W-1:0] clamp_mag(input logic signed [DXW-1:0] d);
    logic [DXW-1:0] a;
    a = d[DXW-1] ? DXW'(-d) : DXW'(d);
    clamp_mag = (a > DXW'(AXIS_CLAMP)) ? AXIS_CLAMP : a[FIX_W-1:0];
  endfunction

  always_comb begin
    if (gw_q == '0) w_eff = CW'(1);
    else if (32'(gw_q) > MAX_GRID_W) w_eff = CW'(MAX_GRID_W);
    else w_eff = $signed(CW'(gw_q));
    if (gh_q == '0) h_eff = CW'(1);
    else if (32'(gh_q) > MAX_GRID_H) h_eff = CW'(MAX_GRID_H);
    else h_eff = $signed(CW'(gh_q));
    maxlv    = (w_eff > h_eff) ? w_eff : h_eff;
    step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  end

  assign ddx = (FIX_W+1)'(point_x_i) - (FIX_W+1)'(ox_q);
  assign ddy = (FIX_W+1)'(point_y_i) - (FIX_W+1)'(oy_q);

  // restoring divider, one quotient bit per cycle
  assign div_trial = {rem_q[FIX_W-2:0], quo_q[FIX_W-1]};
  assign div_bit   = div_trial >= FIX_W'(step_eff);
  assign div_rem   = div_bit ? div_trial - FIX_W'(step_eff) : div_trial;

  // ring side bounds
  always_comb begin
    is_col  = (side_q == SIDE_LEFT) || (side_q == SIDE_RIGHT);
    fix_row = (side_q == SIDE_BOTTOM) ? y_q + lv_q : y_q - lv_q;
    fix_col = (side_q == SIDE_RIGHT) ? x_q + lv_q : x_q - lv_q;
    row_lo  = (x_q - lv_q < 0) ? '0 : x_q - lv_q;
    row_hi  = (x_q + lv_q > w_eff - 1) ? w_eff - 1 : x_q + lv_q;
    col_lo  = (y_q - lv_q + 1 < 0) ? '0 : y_q - lv_q + 1;
    col_hi  = (y_q + lv_q - 1 > h_eff - 1) ? h_eff - 1 : y_q + lv_q - 1;
    if (is_col) begin
      fix_c  = fix_col;
      fix_ok = (fix_col >= 0) && (fix_col < w_eff);
      lo_c   = col_lo;
      hi_c   = col_hi;
      cur_c  = cj_q;
    end else begin
      fix_c  = fix_row;
      fix_ok = (fix_row >= 0) && (fix_row < h_eff);
      lo_c   = row_lo;
      hi_c   = row_hi;
      cur_c  = ci_q;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_I: begin
        mul_a = FIX_W'($unsigned(ci_q));
        mul_b = FIX_W'(step_eff);
      end
      MUL_J: begin
        mul_a = FIX_W'($unsigned(cj_q));
        mul_b = FIX_W'(step_eff);
      end
      MUL_AX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      MUL_AY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dx_x   = $signed(DXW'(prod_q[FIX_W+9:0])) + DXW'(offx_q);
  assign dx_y   = $signed(DXW'(prod_q[FIX_W+9:0])) + DXW'(offy_q);
  assign mag_x  = clamp_mag(dx_x);
  assign mag_y  = clamp_mag(dx_y);
  assign sum_sq = acc_q + prod_q;
  assign sq_t   = sres_q + sbit_q;
  assign dsat   = (sres_q > DIST_MAX) ? DIST_MAX[FIX_W-1:0] : sres_q[FIX_W-1:0];

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.pix_wr && (32'(cell_x_i) < MAX_GRID_W) && (32'(cell_y_i) < MAX_GRID_H)) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cell_y_i) * AW'(MAX_GRID_W) + AW'(cell_x_i);
      mem_wdata = pixel_value_i;
    end
  end
  assign mem_raddr = AW'($unsigned(cj_q)) * AW'(MAX_GRID_W) + AW'($unsigned(ci_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q        <= DIM_REG_W'(64);
      gh_q        <= DIM_REG_W'(64);
      ox_q        <= '0;
      oy_q        <= '0;
      step_q      <= STEP_W'(65536);
      clr_q       <= '0;
      dcnt_q      <= '0;
      sbit_q      <= '0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_W:    gw_q   <= cfg_wdata_i[DIM_REG_W-1:0];
          REG_GRID_H:    gh_q   <= cfg_wdata_i[DIM_REG_W-1:0];
          REG_ORIGIN_X:  ox_q   <= $signed(cfg_wdata_i[FIX_W-1:0]);
          REG_ORIGIN_Y:  oy_q   <= $signed(cfg_wdata_i[FIX_W-1:0]);
          REG_CELL_STEP: step_q <= cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.capture || cmd_i.div_to_y) dcnt_q <= DCNT_W'(DIV_STEPS);
      else if (cmd_i.div_step) dcnt_q <= dcnt_q - DCNT_W'(1);
      if (cmd_i.sqrt_load) sbit_q <= PW'(1) << (PW - 2);
      else if (cmd_i.sqrt_step) sbit_q <= sbit_q >> 2;
      if (cmd_i.ring_first) bv_q <= 1'b0;
      else if (cmd_i.upd_best && (!bv_q || sum_sq < best_q)) bv_q <= 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      offx_q   <= -ddx;
      offy_q   <= -ddy;
      negx_q   <= ddx[FIX_W];
      negy_q   <= ddy[FIX_W];
      dvd_y_q  <= ddy[FIX_W-1:0];
      quo_q    <= ddx[FIX_W-1:0];
      rem_q    <= '0;
      inside_q <= 1'b0;
    end else if (cmd_i.div_to_y) begin
      qx_q  <= quo_q;
      quo_q <= dvd_y_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[FIX_W-2:0], div_bit};
      rem_q <= div_rem;
    end
    if (cmd_i.div_fin_y) qy_q <= quo_q;
    if (cmd_i.in_acc) inside_q <= inside_q | rd_q;

    if (cmd_i.ctr_load) begin
      x_q  <= $signed(qx_q[CW-1:0]);
      y_q  <= $signed(qy_q[CW-1:0]);
      ci_q <= $signed(qx_q[CW-1:0]);
      cj_q <= $signed(qy_q[CW-1:0]);
    end else if (cmd_i.in_load) begin
      ci_q   <= '0;
      cj_q   <= y_q;
      end_q  <= x_q - 1;
      side_q <= SIDE_TOP;
    end else if (cmd_i.seg_load) begin
      end_q <= hi_c;
      if (is_col) begin
        ci_q <= fix_c;
        cj_q <= lo_c;
      end else begin
        cj_q <= fix_c;
        ci_q <= lo_c;
      end
    end else if (cmd_i.step) begin
      if (is_col) cj_q <= cj_q + 1;
      else ci_q <= ci_q + 1;
    end

    if (cmd_i.ring_first) begin
      lv_q   <= CW'(1);
      side_q <= SIDE_TOP;
    end else if (cmd_i.ring_next) begin
      lv_q   <= lv_q + 1;
      side_q <= SIDE_TOP;
    end else if (cmd_i.side_next) begin
      case (side_q)
        SIDE_TOP:    side_q <= SIDE_BOTTOM;
        SIDE_BOTTOM: side_q <= SIDE_LEFT;
        SIDE_LEFT:   side_q <= SIDE_RIGHT;
        default:     side_q <= SIDE_RIGHT;
      endcase
    end

    if (cmd_i.mul_sel != MUL_NONE) prod_q <= mul_a * mul_b;
    if (cmd_i.ld_ax) ax_q <= mag_x;
    if (cmd_i.ld_ay) ay_q <= mag_y;
    if (cmd_i.ld_acc) acc_q <= prod_q;
    if (cmd_i.upd_best && (!bv_q || sum_sq < best_q)) best_q <= sum_sq;

    if (cmd_i.sqrt_load) begin
      sv_q   <= best_q;
      sres_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (sv_q >= sq_t) begin
        sv_q   <= sv_q - sq_t;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
    end

    if (cmd_i.out_load) begin
      case (cmd_i.res_sel)
        RES_OFF_GRID: begin
          dist_q  <= '0;
          found_q <= 1'b0;
          oog_q   <= 1'b1;
        end
        RES_ON_CELL: begin
          dist_q  <= '0;
          found_q <= 1'b1;
          oog_q   <= 1'b0;
        end
        RES_DIST: begin
          dist_q  <= inside_q ? $signed(dsat) : -$signed(dsat);
          found_q <= 1'b1;
          oog_q   <= 1'b0;
        end
        default: begin
          dist_q  <= '0;
          found_q <= 1'b0;
          oog_q   <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.clr_done   = clr_q == AW'(DEPTH - 1);
    sts_o.div_done   = dcnt_q == '0;
    sts_o.off_grid   = negx_q || negy_q || (qx_q >= FIX_W'($unsigned(w_eff)))
                       || (qy_q >= FIX_W'($unsigned(h_eff)));
    sts_o.x_zero     = x_q == '0;
    sts_o.pix        = rd_q;
    sts_o.at_end     = cur_c == end_q;
    sts_o.seg_ok     = fix_ok && (lo_c <= hi_c);
    sts_o.last_side  = side_q == SIDE_RIGHT;
    sts_o.ring_over  = lv_q > maxlv;
    sts_o.best_valid = bv_q;
    sts_o.sqrt_done  = sbit_q == '0;
    sts_o.out_full   = out_valid_q;
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign found_o       = found_q;
  assign out_of_grid_o = oog_q;

endmodule

// ===== hdl/bsdq_ctrl.sv =====
// controller state machine of the bitmap signed distance query block
`include "bitmap_signed_distance_query_top_macros.svh"
module bsdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  bsdq_pkg::dp_sts_t  sts_i,
  output bsdq_pkg::dp_cmd_t  cmd_o
);
  import bsdq_pkg::*;

  ctrl_state_e state_q, state_d;
  res_sel_e    res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      res_q   <= RES_NONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    res_d         = res_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.res_sel = res_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d = ST_DIV_X;
          end else begin
            cmd_o.pix_wr = 1'b1;
          end
        end
      end
      ST_DIV_X: begin
        if (sts_i.div_done) begin
          cmd_o.div_to_y = 1'b1;
          state_d = ST_DIV_Y;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (sts_i.div_done) begin
          cmd_o.div_fin_y = 1'b1;
          state_d = ST_GRID;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_GRID: begin
        if (sts_i.off_grid) begin
          res_d = RES_OFF_GRID;
          state_d = ST_FIN;
        end else begin
          cmd_o.ctr_load = 1'b1;
          state_d = ST_CTR_RD;
        end
      end
      ST_CTR_RD: state_d = ST_CTR_CK;
      ST_CTR_CK: begin
        if (sts_i.pix) begin
          res_d = RES_ON_CELL;
          state_d = ST_FIN;
        end else if (sts_i.x_zero) begin
          cmd_o.ring_first = 1'b1;
          state_d = ST_RING;
        end else begin
          cmd_o.in_load = 1'b1;
          state_d = ST_IN_RD;
        end
      end
      ST_IN_RD: state_d = ST_IN_CK;
      ST_IN_CK: begin
        cmd_o.in_acc = 1'b1;
        if (sts_i.at_end) begin
          cmd_o.ring_first = 1'b1;
          state_d = ST_RING;
        end else begin
          cmd_o.step = 1'b1;
          state_d = ST_IN_RD;
        end
      end
      ST_RING: begin
        if (sts_i.ring_over) begin
          res_d = RES_NONE;
          state_d = ST_FIN;
        end else begin
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        if (sts_i.seg_ok) begin
          cmd_o.seg_load = 1'b1;
          state_d = ST_RNG_RD;
        end else if (!sts_i.last_side) begin
          cmd_o.side_next = 1'b1;
        end else if (sts_i.best_valid) begin
          cmd_o.sqrt_load = 1'b1;
          state_d = ST_SQRT;
        end else begin
          cmd_o.ring_next = 1'b1;
          state_d = ST_RING;
        end
      end
      ST_RNG_RD: state_d = ST_RNG_CK;
      ST_RNG_CK: state_d = sts_i.pix ? ST_D0 : ST_ADV;
      ST_D0: begin
        cmd_o.mul_sel = MUL_I;
        state_d = ST_D1;
      end
      ST_D1: begin
        cmd_o.ld_ax = 1'b1;
        cmd_o.mul_sel = MUL_J;
        state_d = ST_D2;
      end
      ST_D2: begin
        cmd_o.ld_ay = 1'b1;
        cmd_o.mul_sel = MUL_AX;
        state_d = ST_D3;
      end
      ST_D3: begin
        cmd_o.ld_acc = 1'b1;
        cmd_o.mul_sel = MUL_AY;
        state_d = ST_D4;
      end
      ST_D4: begin
        cmd_o.upd_best = 1'b1;
        state_d = ST_ADV;
      end
      ST_ADV: begin
        if (!sts_i.at_end) begin
          cmd_o.step = 1'b1;
          state_d = ST_RNG_RD;
        end else if (!sts_i.last_side) begin
          cmd_o.side_next = 1'b1;
          state_d = ST_SEG;
        end else if (sts_i.best_valid) begin
          cmd_o.sqrt_load = 1'b1;
          state_d = ST_SQRT;
        end else begin
          cmd_o.ring_next = 1'b1;
          state_d = ST_RING;
        end
      end
      ST_SQRT: begin
        if (sts_i.sqrt_done) begin
          res_d = RES_DIST;
          state_d = ST_FIN;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BSDQ_ASSERT_IMPL(a_out_load_free, cmd_o.out_load, !sts_i.out_full || out_ready_i)
  `BSDQ_ASSERT_NEXT(a_query_starts_div, in_valid_i && in_ready_o && (in_kind_i == KIND_QUERY), state_q == ST_DIV_X)
  `BSDQ_ASSERT_IMPL(a_sqrt_has_best, cmd_o.sqrt_load, sts_i.best_valid)
  `BSDQ_ASSERT_IMPL(a_ready_only_idle, in_ready_o, (state_q == ST_IDLE) && (res_q == res_d))

endmodule

// ===== hdl/bitmap_signed_distance_query_top.sv =====
// top level of the bitmap signed distance query block
// A write item is written to the pixel memory as it is accepted. A query takes two 32-step
// divisions to find its cell, then reads each pixel left of the query cell in its row, then
// walks rings of cells read from the pixel memory, with a distance step for each set cell met,
// side by side, and ends in a square root when a set cell is found. After reset the pixel
// memory is cleared one entry per cycle, all MAX_GRID_W * MAX_GRID_H entries, before the first
// item is taken. A result waits in the output register while the next item may already be taken.
module bitmap_signed_distance_query_top #(
  parameter int MAX_GRID_W = 64,
  parameter int MAX_GRID_H = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bsdq_in_if.sink                           in_ch,
  bsdq_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [bsdq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bsdq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import bsdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bsdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_kind_i   (in_ch.kind),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsdq_datapath #(
    .MAX_GRID_W (MAX_GRID_W),
    .MAX_GRID_H (MAX_GRID_H)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_x_i      (in_ch.cell_x),
    .cell_y_i      (in_ch.cell_y),
    .pixel_value_i (in_ch.pixel_value),
    .point_x_i     (in_ch.point_x),
    .point_y_i     (in_ch.point_y),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .distance_o    (out_ch.distance),
    .found_o       (out_ch.found),
    .out_of_grid_o (out_ch.out_of_grid)
  );

endmodule

// ===== test/bitmap_signed_distance_query_top_tb.sv =====
// self-checking testbench of the bitmap signed distance query block
module bitmap_signed_distance_query_top_tb;
  import bsdq_pkg::*;

  typedef struct packed {
    logic signed [31:0] distance;
    logic               found;
    logic               out_of_grid;
  } answer_t;

  typedef struct {
    kind_e              kind;
    logic [5:0]         cx;
    logic [5:0]         cy;
    logic               pv;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               has_exp;
    answer_t            exp_ans;
  } stim_t;

  localparam int GRID_MAX = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  bsdq_in_if in_ch ();
  bsdq_out_if out_ch ();

  bitmap_signed_distance_query_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // shadow state
  bit       bitmap [GRID_MAX*GRID_MAX];
  int unsigned sh_w = 64, sh_h = 64;
  longint   sh_ox = 0, sh_oy = 0;
  longint unsigned sh_step = 65536;

  answer_t  pending_answers [$];
  int       errors = 0;
  bit       sink_idle_en = 1'b1;
  bit       long_stall_req = 1'b0;
  longint   cycles = 0;

  // nearest-pixel search state
  longint   q_x, q_y;
  bit       nb_valid;
  longint unsigned nb_sq;

  function automatic longint unsigned clamp_axis(longint d);
    longint unsigned a;
    a = d < 0 ? -d : d;
    return a > 64'd2147483648 ? 64'd2147483648 : a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void try_cell(longint i, longint j);
    longint dx, dy;
    longint unsigned ax, ay, sq;
    if (!bitmap[j*GRID_MAX+i]) return;
    dx = i * longint'(sh_step) + sh_ox - q_x;
    dy = j * longint'(sh_step) + sh_oy - q_y;
    ax = clamp_axis(dx);
    ay = clamp_axis(dy);
    sq = ax*ax + ay*ay;
    if (!nb_valid || sq < nb_sq) begin
      nb_valid = 1'b1;
      nb_sq = sq;
    end
  endfunction

  function automatic answer_t signed_distance(longint px, longint py);
    answer_t a;
    longint w, h, cx, cy, lo, hi, r, rmax;
    longint unsigned d;
    bit left_set;
    w = sh_w < 1 ? 1 : (sh_w > GRID_MAX ? GRID_MAX : sh_w);
    h = sh_h < 1 ? 1 : (sh_h > GRID_MAX ? GRID_MAX : sh_h);
    q_x = px;
    q_y = py;
    cx = (px - sh_ox) >= 0 ? (px - sh_ox) / longint'(sh_step) : -1;
    cy = (py - sh_oy) >= 0 ? (py - sh_oy) / longint'(sh_step) : -1;
    a = '0;
    if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
      a.out_of_grid = 1'b1;
      return a;
    end
    if (bitmap[cy*GRID_MAX+cx]) begin
      a.found = 1'b1;
      return a;
    end
    left_set = 1'b0;
    for (longint i = 0; i < cx; i++) if (bitmap[cy*GRID_MAX+i]) left_set = 1'b1;
    nb_valid = 1'b0;
    nb_sq = 0;
    rmax = w > h ? w : h;
    for (r = 0; r <= rmax && !nb_valid; r++) begin
      lo = cx - r < 0 ? 0 : cx - r;
      hi = cx + r > w - 1 ? w - 1 : cx + r;
      if (cy - r >= 0 && cy - r < h) for (longint i = lo; i <= hi; i++) try_cell(i, cy - r);
      if (cy + r >= 0 && cy + r < h) for (longint i = lo; i <= hi; i++) try_cell(i, cy + r);
      lo = cy - r + 1 < 0 ? 0 : cy - r + 1;
      hi = cy + r - 1 > h - 1 ? h - 1 : cy + r - 1;
      if (cx - r >= 0 && cx - r < w) for (longint j = lo; j <= hi; j++) try_cell(cx - r, j);
      if (cx + r >= 0 && cx + r < w) for (longint j = lo; j <= hi; j++) try_cell(cx + r, j);
    end
    if (!nb_valid) return a;
    d = int_sqrt(nb_sq);
    if (d > 64'd2147483647) d = 64'd2147483647;
    a.distance = left_set ? d[31:0] : -d[31:0];
    a.found = 1'b1;
    return a;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_W:    sh_w = val[6:0];
      REG_GRID_H:    sh_h = val[6:0];
      REG_ORIGIN_X:  sh_ox = longint'(signed'(val));
      REG_ORIGIN_Y:  sh_oy = longint'(signed'(val));
      REG_CELL_STEP: sh_step = val[30:0] == 0 ? 1 : val[30:0];
      default: ;
    endcase
  endtask

  // waits until all answers are in, then for the tail of a write-free query
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (64*64*8 + 200) @(posedge clk_i);
  endtask

  task automatic send_item(stim_t s, bit idle_en);
    answer_t a;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= s.kind;
    in_ch.cell_x <= s.cx;
    in_ch.cell_y <= s.cy;
    in_ch.pixel_value <= s.pv;
    in_ch.point_x <= s.px;
    in_ch.point_y <= s.py;
    do @(posedge clk_i); while (!in_ch.ready);
    if (s.kind == KIND_WRITE) begin
      bitmap[s.cy*GRID_MAX+s.cx] = s.pv;
    end else begin
      a = signed_distance(s.px, s.py);
      if (s.has_exp && a != s.exp_ans) begin
        $error("directed row mismatch: expected %h predicted %h", s.exp_ans, a);
        errors++;
      end
      pending_answers.insert(pending_answers.size(), a);
    end
  endtask

  function automatic stim_t mk_wr(int x, int y, bit v);
    stim_t s;
    s = '{KIND_WRITE, x[5:0], y[5:0], v, $urandom(), $urandom(), 1'b0, '0};
    return s;
  endfunction

  function automatic stim_t mk_q(logic [31:0] x, logic [31:0] y, bit he, answer_t e);
    stim_t s;
    s = '{KIND_QUERY, 6'($urandom()), 6'($urandom()), 1'($urandom()), x, y, he, e};
    return s;
  endfunction

  // random content, mostly on grid with the current registers
  function automatic stim_t rand_item(int phase);
    stim_t s;
    longint span;
    if ($urandom_range(0, 2) == 0) begin
      s = mk_wr($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3) != 0);
      if (phase == 1) begin
        s.cx = $urandom_range(0, 9);
        s.cy = $urandom_range(0, 9);
      end
    end else if ($urandom_range(0, 9) == 0) begin
      s = mk_q($urandom(), $urandom(), 1'b0, '0);
    end else begin
      span = longint'(sh_step) * (sh_w + 2);
      s = mk_q(32'(sh_ox + longint'($urandom_range(0, 32'hffff_ffff)) % span - sh_step),
               32'(sh_oy + longint'($urandom_range(0, 32'hffff_ffff)) % span - sh_step),
               1'b0, '0);
    end
    return s;
  endfunction

  // result side
  initial begin
    answer_t got, want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.distance, out_ch.found, out_ch.out_of_grid};
        if (pending_answers.size() == 0) begin
          $error("unexpected result %h", got);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d actual %0d", want.distance, got.distance);
            errors++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b actual %0b", want.found, got.found);
            errors++;
          end
          if (got.out_of_grid !== want.out_of_grid) begin
            $error("out_of_grid: expected %0b actual %0b", want.out_of_grid,
                   got.out_of_grid);
            errors++;
          end
        end
      end
      if (long_stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        long_stall_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 64'd200_000_000) begin
        $display("FAIL bitmap_signed_distance_query_top");
        $finish;
      end
    end
  end

  initial begin
    stim_t dir_rows [$];
    answer_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    in_ch.pixel_value = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    foreach (bitmap[k]) bitmap[k] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    dir_rows = {
      mk_q(32'h0001_8000, 32'h0002_0000, 1'b1, none),
      mk_q(32'hffff_ffff, 32'h0, 1'b1, '{32'sd0, 1'b0, 1'b1}),
      mk_q(32'h0, 32'h0040_0000, 1'b1, '{32'sd0, 1'b0, 1'b1}),
      mk_q(32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'sd0, 1'b0, 1'b1}),
      mk_wr(5, 5, 1'b1),
      mk_q(32'h0005_8000, 32'h0005_8000, 1'b1, '{32'sd0, 1'b1, 1'b0}),
      mk_q(32'h000a_0000, 32'h0005_0000, 1'b0, none),
      mk_q(32'h0000_0000, 32'h0005_0000, 1'b0, none),
      mk_wr(63, 63, 1'b1),
      mk_wr(0, 0, 1'b1),
      mk_q(32'h003f_ffff, 32'h003f_ffff, 1'b1, '{32'sd0, 1'b1, 1'b0}),
      mk_q(32'h0020_0000, 32'h0030_0000, 1'b0, none),
      mk_wr(2, 5, 1'b1),
      mk_q(32'h0004_0000, 32'h0005_0000, 1'b0, none),
      mk_wr(5, 5, 1'b0),
      mk_wr(2, 5, 1'b0),
      mk_wr(63, 63, 1'b0),
      mk_wr(0, 0, 1'b0),
      mk_q(32'h0010_0000, 32'h0010_0000, 1'b1, none)
    };
    foreach (dir_rows[k]) send_item(dir_rows[k], 1'b1);
    drain();

    // phase settings: small grid, extremes of origin and step
    write_reg(REG_GRID_W, 32'd10);
    write_reg(REG_GRID_H, 32'd10);
    write_reg(REG_CELL_STEP, 32'h0000_0001);
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h7fff_fff0);
    for (int k = 0; k < 250; k++) send_item(rand_item(1), 1'b1);
    drain();

    write_reg(REG_CELL_STEP, 32'h7fff_ffff);
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(REG_GRID_W, 32'd1);
    write_reg(REG_GRID_H, 32'd2);
    for (int k = 0; k < 150; k++) send_item(rand_item(1), 1'b1);
    drain();

    write_reg(REG_GRID_W, 32'd127);
    write_reg(REG_GRID_H, 32'd0);
    write_reg(REG_CELL_STEP, 32'h0);
    write_reg(REG_ORIGIN_X, 32'h0);
    write_reg(REG_ORIGIN_Y, 32'h0);
    for (int k = 0; k < 100; k++) send_item(rand_item(1), 1'b1);
    drain();

    write_reg(REG_GRID_W, 32'd16);
    write_reg(REG_GRID_H, 32'd12);
    write_reg(REG_CELL_STEP, 32'h0000_4000);
    write_reg(REG_ORIGIN_X, 32'hfffe_0000);
    write_reg(REG_ORIGIN_Y, 32'h0003_0000);
    long_stall_req = 1'b1;
    for (int k = 0; k < 600; k++) send_item(rand_item(0), 1'b1);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
    for (int k = 0; k < 300; k++) send_item(rand_item(0), 1'b1);
    drain();

    write_reg(REG_GRID_W, 32'd64);
    write_reg(REG_GRID_H, 32'd64);
    write_reg(REG_CELL_STEP, 32'h0001_0000);
    sink_idle_en = 1'b0;
    for (int k = 0; k < 430; k++) send_item(rand_item(0), 1'b0);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS bitmap_signed_distance_query_top");
    end else begin
      $display("FAIL bitmap_signed_distance_query_top");
    end
    $finish;
  end

endmodule

// ===== bitmap_signed_distance_query_top.f =====
+incdir+hdl
hdl/bsdq_pkg.sv
hdl/bsdq_if.sv
hdl/bsdq_datapath.sv
hdl/bsdq_ctrl.sv
hdl/bitmap_signed_distance_query_top.sv
test/bitmap_signed_distance_query_top_tb.sv
